[sv/ldlpc_pkg.sv]
// ----------------------------------------------------------------------------
// ldlpc_pkg
// Shared types and constants of the Levinson-Durbin LPC core.
// ----------------------------------------------------------------------------
package ldlpc_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LAG0,
		ST_LAG1,
		ST_K1,
		ST_DIV,
		ST_INIT_A0,
		ST_INIT_A1,
		ST_INIT_ERR,
		ST_SUM,
		ST_CHK,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_WL,
		ST_UPD_WJ,
		ST_AI,
		ST_ERR,
		ST_FIN,
		ST_OUT
	} state_t;

	// coefficient memory regions: two predictor banks and the reflection list
	localparam logic [1:0] RG_REFL = 2'd2;

	localparam logic signed [15:0] Q12_ONE  = 16'sd4096;
	localparam logic signed [15:0] K_LIMIT  = 16'sd32750;
	localparam int                 DIV_BITS = 15;

	typedef struct packed {
		logic               done;
		logic signed [15:0] quot;
	} div_res_t;

endpackage

[sv/levinson_durbin_lpc_core.sv]
// ----------------------------------------------------------------------------
// levinson_durbin_lpc_core
// Fixed-point Levinson-Durbin recursion over lags held in a lag memory, with
// predictor banks and reflection coefficients in one coefficient memory.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            lag_value, final_lag
//  result    strobe                 coef_index, lpc_coef, refl_coef,
//                                   pred_error, stable, last_coef
//
//  A non-final lag is stored without raising busy. A final lag holds busy
//  through lag setup and k1, then per stage through the divider, the dot
//  product and a read, a multiply and two writes per coefficient pair, and
//  through the read-out; a failed stage ends it early and a saturated quotient
//  shortens the divide. Results strobe on ORDER+1 consecutive cycles, the last
//  just after busy drops; they cannot be stalled.
//  Reset clears control state only; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module levinson_durbin_lpc_core #(
	parameter int ORDER = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] lag_value,
	input  logic               final_lag,
	output logic               strobe,
	output logic [4:0]         coef_index,
	output logic signed [15:0] lpc_coef,
	output logic signed [15:0] refl_coef,
	output logic [30:0]        pred_error,
	output logic               stable,
	output logic               last_coef
);
	import ldlpc_pkg::*;

	localparam int IW = $clog2(ORDER + 1);
	localparam int AW = IW + 2;
	localparam int SW = 48 + $clog2(ORDER);
	localparam int NW = SW + 4;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sd32767)
			return 16'sd32767;
		if (x < -32'sd32768)
			return -16'sd32768;
		return x[15:0];
	endfunction

	function automatic logic [30:0] clamp_err(input logic signed [SW-1:0] e);
		if (e < SW'(1))
			return 31'd1;
		if (e > $signed({{(SW-31){1'b0}}, {31{1'b1}}}))
			return {31{1'b1}};
		return e[30:0];
	endfunction

	function automatic logic signed [31:0] rnd15(input logic signed [31:0] p);
		return (p + 32'sd16384) >>> 15;
	endfunction

	// memories
	logic signed [31:0] lag_mem [ORDER+1];
	logic signed [15:0] coef_mem [1 << AW];

	state_t state_q, state_d;

	logic [IW-1:0]      lag_cnt_q;
	logic [IW-1:0]      lag_ra;
	logic signed [31:0] lag_rd_q;
	logic               cm_we;
	logic [AW-1:0]      cm_wa, cm_ra_a, cm_ra_b;
	logic signed [15:0] cm_wd;
	logic signed [15:0] rd_a_q, rd_b_q;

	logic               div_start;
	logic signed [NW-1:0] div_num;
	logic [30:0]        div_den;
	div_res_t           div_res;

	logic signed [31:0] r0_q, r1_q, r1c;
	logic [30:0]        err_q;
	logic [IW-1:0]      stage_q, j_q, l_idx;
	logic signed [SW-1:0] s_q;
	logic signed [15:0] kc_q, k1_q, k2_q, prev_refl0_q, prev_refl1_q;
	logic signed [15:0] aj_q, al_q;
	logic signed [31:0] pj_q, pl_q;
	logic signed [NW-1:0] mulerr_q;
	logic               prev_sel_q, prev_init_q, stable_q;
	logic [IW-1:0]      refl_cnt_q;
	logic               rd_v_s1, is_r1_s1, mv_s2;
	logic signed [47:0] prod_s2;
	logic signed [31:0] r_sel;
	logic               issue, sum_done, accept, kc_bad;
	logic               out_v_s1;
	logic [IW-1:0]      out_k_s1;
	logic [1:0]         rg_work, rg_prev;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE) || out_v_s1;
	assign rg_work  = {1'b0, ~prev_sel_q};
	assign rg_prev  = {1'b0, prev_sel_q};
	assign l_idx    = stage_q - j_q;
	assign issue    = (state_q == ST_SUM) && (j_q != stage_q);
	assign sum_done = (state_q == ST_SUM) && (j_q == stage_q) && !rd_v_s1 && !mv_s2;
	assign r1c      = (lag_rd_q > r0_q) ? r0_q : lag_rd_q;
	assign r_sel    = is_r1_s1 ? r1_q : lag_rd_q;
	assign kc_bad   = (kc_q > K_LIMIT) || (kc_q < -K_LIMIT);

	ldlpc_div #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		lag_ra    = '0;
		cm_we     = 1'b0;
		cm_wa     = {rg_work, j_q};
		cm_wd     = '0;
		cm_ra_a   = {rg_work, j_q};
		cm_ra_b   = {rg_work, l_idx};
		div_start = 1'b0;
		div_num   = -(NW'(s_q) <<< 3);
		div_den   = err_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && final_lag)
					state_d = ST_LAG0;
			end
			ST_LAG0: begin
				state_d = ST_LAG1;
			end
			ST_LAG1: begin
				lag_ra  = IW'(1);
				state_d = ST_K1;
			end
			ST_K1: begin
				div_start = 1'b1;
				div_num   = -(NW'(r1c) <<< 15);
				div_den   = r0_q[30:0];
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done)
					state_d = (stage_q == IW'(1)) ? ST_INIT_A0 : ST_CHK;
			end
			ST_INIT_A0: begin
				cm_we   = 1'b1;
				cm_wa   = {RG_REFL, IW'(0)};
				cm_wd   = kc_q;
				state_d = ST_INIT_A1;
			end
			ST_INIT_A1: begin
				cm_we   = 1'b1;
				cm_wa   = {rg_work, IW'(0)};
				cm_wd   = Q12_ONE;
				state_d = ST_INIT_ERR;
			end
			ST_INIT_ERR: begin
				cm_we   = 1'b1;
				cm_wa   = {rg_work, IW'(1)};
				cm_wd   = 16'((17'(kc_q) + 17'sd4) >>> 3);
				state_d = ST_SUM;
			end
			ST_SUM: begin
				lag_ra = l_idx;
				if (sum_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_CHK: begin
				cm_we   = 1'b1;
				cm_wa   = {RG_REFL, stage_q - IW'(1)};
				cm_wd   = kc_q;
				state_d = kc_bad ? ST_FIN : ST_UPD_RD;
			end
			ST_UPD_RD: begin
				state_d = ST_UPD_MUL;
			end
			ST_UPD_MUL: begin
				state_d = ST_UPD_WL;
			end
			ST_UPD_WL: begin
				cm_we   = 1'b1;
				cm_wa   = {rg_work, l_idx};
				cm_wd   = sat16(32'(al_q) + rnd15(pj_q));
				state_d = ST_UPD_WJ;
			end
			ST_UPD_WJ: begin
				cm_we   = 1'b1;
				cm_wd   = sat16(32'(aj_q) + rnd15(pl_q));
				state_d = (j_q == (stage_q >> 1)) ? ST_AI : ST_UPD_RD;
			end
			ST_AI: begin
				cm_we   = 1'b1;
				cm_wa   = {rg_work, stage_q};
				cm_wd   = 16'((17'(kc_q) + 17'sd4) >>> 3);
				state_d = ST_ERR;
			end
			ST_ERR: begin
				state_d = (stage_q == IW'(ORDER)) ? ST_FIN : ST_SUM;
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cm_ra_a = {rg_prev, j_q};
				cm_ra_b = {RG_REFL, j_q - IW'(1)};
				if (j_q == IW'(ORDER))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// lag memory: write on request, one read port
	always_ff @(posedge clk) begin
		if (accept) begin
			if (final_lag)
				lag_mem[ORDER] <= lag_value;
			else if (lag_cnt_q < IW'(ORDER))
				lag_mem[lag_cnt_q] <= lag_value;
		end
		lag_rd_q <= lag_mem[lag_ra];
	end

	// coefficient memory: one write port, two read ports
	always_ff @(posedge clk) begin
		if (cm_we)
			coef_mem[cm_wa] <= cm_wd;
		rd_a_q <= coef_mem[cm_ra_a];
		rd_b_q <= coef_mem[cm_ra_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_cnt_q    <= '0;
			prev_sel_q   <= 1'b0;
			prev_init_q  <= 1'b1;
			stable_q     <= 1'b1;
			refl_cnt_q   <= '0;
			rd_v_s1      <= 1'b0;
			mv_s2        <= 1'b0;
			out_v_s1     <= 1'b0;
			strobe       <= 1'b0;
			prev_refl0_q <= '0;
			prev_refl1_q <= '0;
		end else begin
			if (accept) begin
				if (final_lag)
					lag_cnt_q <= '0;
				else if (lag_cnt_q < IW'(ORDER))
					lag_cnt_q <= lag_cnt_q + IW'(1);
			end
			rd_v_s1  <= issue;
			mv_s2    <= rd_v_s1;
			out_v_s1 <= (state_q == ST_OUT);
			strobe   <= out_v_s1;
			if (state_q == ST_K1) begin
				stable_q   <= 1'b1;
				refl_cnt_q <= IW'(1);
			end
			if (state_q == ST_CHK) begin
				refl_cnt_q <= stage_q;
				if (kc_bad)
					stable_q <= 1'b0;
			end
			// commit the new predictor of a stable frame by swapping banks
			if (state_q == ST_FIN && stable_q) begin
				prev_sel_q   <= ~prev_sel_q;
				prev_init_q  <= 1'b0;
				prev_refl0_q <= k1_q;
				prev_refl1_q <= k2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		is_r1_s1 <= (l_idx == IW'(1));
		if (mv_s2)
			s_q <= s_q + SW'(prod_s2);
		if (rd_v_s1)
			prod_s2 <= 48'(r_sel) * 48'(rd_a_q);
		if (issue)
			j_q <= j_q + IW'(1);
		out_k_s1 <= j_q;
		unique case (state_q)
			ST_LAG1: r0_q <= (lag_rd_q < 32'sd1) ? 32'sd1 : lag_rd_q;
			ST_K1: begin
				r1_q    <= r1c;
				stage_q <= IW'(1);
			end
			ST_DIV: begin
				if (div_res.done)
					kc_q <= div_res.quot;
			end
			ST_INIT_A0: begin
				k1_q    <= kc_q;
				prod_s2 <= 48'(r1_q) * 48'(kc_q);
			end
			ST_INIT_ERR: begin
				err_q   <= clamp_err(SW'(r0_q) + SW'(prod_s2 >>> 15));
				stage_q <= IW'(2);
				j_q     <= '0;
				s_q     <= '0;
			end
			ST_CHK: begin
				if (stage_q == IW'(2))
					k2_q <= kc_q;
				j_q <= IW'(1);
			end
			ST_UPD_MUL: begin
				aj_q <= rd_a_q;
				al_q <= rd_b_q;
				pj_q <= 32'(kc_q) * 32'(rd_a_q);
				pl_q <= 32'(kc_q) * 32'(rd_b_q);
			end
			ST_UPD_WJ: j_q <= j_q + IW'(1);
			ST_AI: mulerr_q <= NW'($signed(s_q[SW-1:12])) * NW'(kc_q);
			ST_ERR: begin
				err_q   <= clamp_err(SW'($signed({1'b0, err_q})) + SW'(mulerr_q >>> 15));
				stage_q <= stage_q + IW'(1);
				j_q     <= '0;
				s_q     <= '0;
			end
			ST_FIN: j_q <= '0;
			ST_OUT: j_q <= j_q + IW'(1);
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		coef_index <= 5'(out_k_s1);
		last_coef  <= (out_k_s1 == IW'(ORDER));
		stable     <= stable_q;
		pred_error <= stable_q ? err_q : 31'd1;
		if (prev_init_q)
			lpc_coef <= (out_k_s1 == '0) ? Q12_ONE : 16'sd0;
		else
			lpc_coef <= rd_a_q;
		priority if (out_k_s1 == '0)
			refl_coef <= 16'sd0;
		else if (out_k_s1 == IW'(1))
			refl_coef <= prev_refl0_q;
		else if (out_k_s1 == IW'(2))
			refl_coef <= prev_refl1_q;
		else if (out_k_s1 <= refl_cnt_q)
			refl_coef <= rd_b_q;
		else
			refl_coef <= 16'sd0;
	end

endmodule

[sv/ldlpc_div.sv]
// ----------------------------------------------------------------------------
// ldlpc_div
// Saturating signed divider, one quotient bit per cycle, Q15 result range.
// ----------------------------------------------------------------------------
module ldlpc_div #(
	parameter int NW = 56
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [30:0]          den,
	output ldlpc_pkg::div_res_t  res
);
	import ldlpc_pkg::*;

	localparam int RW = 31 + DIV_BITS;

	logic [NW-1:0] mag;
	logic          sat;
	logic          run_q;
	logic          done_q;
	logic          neg_q;
	logic          sat_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsh_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [3:0]    cnt_q;
	logic          ge;

	assign mag = num[NW-1] ? NW'(-num) : NW'(num);
	assign sat = mag >= NW'({den, {DIV_BITS{1'b0}}});
	assign ge  = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !sat;
				done_q <= sat;
			end else if (run_q && cnt_q == 4'd0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			sat_q <= sat;
			rem_q <= mag[RW-1:0];
			dsh_q <= RW'({den, {(DIV_BITS-1){1'b0}}});
			quo_q <= '0;
			cnt_q <= 4'(DIV_BITS - 1);
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_comb begin
		res.done = done_q;
		if (sat_q)
			res.quot = neg_q ? -16'sd32768 : 16'sd32767;
		else if (neg_q)
			res.quot = -$signed({1'b0, quo_q});
		else
			res.quot = $signed({1'b0, quo_q});
	end

endmodule

[sv/ldlpc_chk.sv]
// ----------------------------------------------------------------------------
// ldlpc_chk
// Port-level checks of the Levinson-Durbin LPC core.
// ----------------------------------------------------------------------------
module ldlpc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [31:0] lag_value,
	input logic               final_lag,
	input logic               strobe,
	input logic [4:0]         coef_index,
	input logic signed [15:0] lpc_coef,
	input logic signed [15:0] refl_coef,
	input logic [30:0]        pred_error,
	input logic               stable,
	input logic               last_coef
);

	a_first_coef: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && coef_index == 5'd0 |-> lpc_coef == 16'sd4096 && refl_coef == 16'sd0)
		else $error("first coefficient is not unity");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_coef |=> strobe && coef_index == $past(coef_index) + 5'd1)
		else $error("result burst broken");

	a_unstable_err: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !stable |-> pred_error == 31'd1)
		else $error("unstable frame error not floored");

	a_err_floor: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> pred_error != 31'd0)
		else $error("prediction error below floor");

	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && final_lag |=> busy)
		else $error("final lag did not start recursion");

endmodule

bind levinson_durbin_lpc_core ldlpc_chk u_chk (.*);
